@@ rtl/xibe_pkg.sv @@
// Package: shared types and constants for the x86 instruction byte encoder.
`default_nettype none
package xibe_pkg;
    localparam int unsigned MaxBytes = 11;
    localparam int unsigned CntW = 4;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_CMP = 4'd3, OP_INC = 4'd4,
        OP_DEC = 4'd5, OP_MUL = 4'd6, OP_DIV = 4'd7, OP_JE = 4'd8, OP_RET = 4'd9
    } t_op;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_IMM = 2'd1;
    localparam logic [1:0] KIND_MEM = 2'd2;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [1:0]  dst_kind;
        logic [2:0]  dst_reg;
        logic [1:0]  src_kind;
        logic [2:0]  src_reg;
        logic [31:0] imm_value;
        logic [3:0]  mem_base;
        logic [3:0]  mem_index;
        logic [1:0]  mem_scale;
        logic [31:0] mem_disp;
    } t_instr;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic       bad_form;
    } t_result;

    // Decoded form: opcode bytes, optional ModRM and imm.
    typedef struct packed {
        logic        bad;
        logic [1:0]  n_op;
        logic [7:0]  op0;
        logic [7:0]  op1;
        logic        has_rm;
        logic        rm_mem;
        logic [2:0]  rm_reg;
        logic [2:0]  rm_direct;
        logic [1:0]  n_imm;    // 0 none, 1 imm8, 2 imm32
        logic [31:0] imm;
    } t_dec;

    // Memory operand layout.
    typedef struct packed {
        logic        bad;
        logic [7:0]  modrm;
        logic        has_sib;
        logic [7:0]  sib;
        logic [1:0]  n_disp;   // 0 none, 1 disp8, 2 disp32
        logic [31:0] disp;
    } t_mem;

    typedef struct packed {
        logic [CntW-1:0] len;
        logic [MaxBytes-1:0][7:0] bytes;
        logic        bad;
    } t_frame;

    function automatic logic fits8(input logic [31:0] v);
        logic [31:0] t;
        begin
            t = v + 32'h80;
            fits8 = (t[31:8] == 24'd0);
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/xibe_if.sv @@
// Interface: valid/ready word channel with payload.
`default_nettype none
interface xibe_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/xibe_decode.sv @@
// Stage 1: mnemonic and operand form decode, memory operand layout.
`default_nettype none
module xibe_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire xibe_pkg::t_instr i_in,
    output logic                 o_valid,
    output xibe_pkg::t_dec       o_dec,
    output xibe_pkg::t_mem       o_mem
);
    xibe_pkg::t_dec n_dec, r_dec;
    xibe_pkg::t_mem n_mem, r_mem;
    logic r_valid;
    logic [2:0] g_ext;
    logic [7:0] g_rmr, g_rrm, g_short;
    logic hb, hi;
    logic [1:0] md;

    always_comb begin
        n_dec = '0;
        n_dec.imm = i_in.imm_value;
        n_dec.n_op = 2'd1;
        case (i_in.opcode)
            xibe_pkg::OP_SUB: begin
                g_ext = 3'd5; g_rmr = 8'h29; g_rrm = 8'h2B; g_short = 8'h2D;
            end
            xibe_pkg::OP_CMP: begin
                g_ext = 3'd7; g_rmr = 8'h39; g_rrm = 8'h3B; g_short = 8'h3D;
            end
            default: begin g_ext = 3'd0; g_rmr = 8'h01; g_rrm = 8'h03; g_short = 8'h05; end
        endcase
        case (i_in.opcode)
            xibe_pkg::OP_MOV: begin
                n_dec.has_rm = 1'b1;
                if (i_in.dst_kind == xibe_pkg::KIND_REG && i_in.src_kind == xibe_pkg::KIND_IMM) begin
                    n_dec.op0 = 8'hB8 + {5'd0, i_in.dst_reg};
                    n_dec.has_rm = 1'b0;
                    n_dec.n_imm = 2'd2;
                end else if (i_in.dst_kind == xibe_pkg::KIND_REG
                             && i_in.src_kind == xibe_pkg::KIND_REG) begin
                    n_dec.op0 = 8'h89;
                    n_dec.rm_reg = i_in.src_reg;
                    n_dec.rm_direct = i_in.dst_reg;
                end else if (i_in.dst_kind == xibe_pkg::KIND_REG
                             && i_in.src_kind == xibe_pkg::KIND_MEM) begin
                    n_dec.op0 = 8'h8B;
                    n_dec.rm_mem = 1'b1;
                    n_dec.rm_reg = i_in.dst_reg;
                end else if (i_in.dst_kind == xibe_pkg::KIND_MEM
                             && i_in.src_kind == xibe_pkg::KIND_REG) begin
                    n_dec.op0 = 8'h89;
                    n_dec.rm_mem = 1'b1;
                    n_dec.rm_reg = i_in.src_reg;
                end else if (i_in.dst_kind == xibe_pkg::KIND_MEM
                             && i_in.src_kind == xibe_pkg::KIND_IMM) begin
                    n_dec.op0 = 8'hC7;
                    n_dec.rm_mem = 1'b1;
                    n_dec.n_imm = 2'd2;
                end else begin
                    n_dec.bad = 1'b1;
                end
            end
            xibe_pkg::OP_ADD, xibe_pkg::OP_SUB, xibe_pkg::OP_CMP: begin
                n_dec.has_rm = 1'b1;
                n_dec.rm_mem = (i_in.dst_kind == xibe_pkg::KIND_MEM);
                n_dec.rm_direct = i_in.dst_reg;
                if (i_in.dst_kind != xibe_pkg::KIND_REG && i_in.dst_kind != xibe_pkg::KIND_MEM) begin
                    n_dec.bad = 1'b1;
                end else if (i_in.src_kind == xibe_pkg::KIND_REG) begin
                    n_dec.op0 = g_rmr;
                    n_dec.rm_reg = i_in.src_reg;
                end else if (i_in.src_kind == xibe_pkg::KIND_MEM) begin
                    n_dec.bad = (i_in.dst_kind != xibe_pkg::KIND_REG);
                    n_dec.op0 = g_rrm;
                    n_dec.rm_mem = 1'b1;
                    n_dec.rm_reg = i_in.dst_reg;
                end else if (i_in.src_kind == xibe_pkg::KIND_IMM) begin
                    n_dec.rm_reg = g_ext;
                    if (xibe_pkg::fits8(i_in.imm_value)) begin
                        n_dec.op0 = 8'h83;
                        n_dec.n_imm = 2'd1;
                    end else if (i_in.dst_kind == xibe_pkg::KIND_REG && i_in.dst_reg == 3'd0) begin
                        n_dec.op0 = g_short;
                        n_dec.has_rm = 1'b0;
                        n_dec.n_imm = 2'd2;
                    end else begin
                        n_dec.op0 = 8'h81;
                        n_dec.n_imm = 2'd2;
                    end
                end else begin
                    n_dec.bad = 1'b1;
                end
            end
            xibe_pkg::OP_INC, xibe_pkg::OP_DEC: begin
                if (i_in.dst_kind == xibe_pkg::KIND_REG) begin
                    n_dec.op0 = (i_in.opcode == xibe_pkg::OP_INC ? 8'h40 : 8'h48)
                                + {5'd0, i_in.dst_reg};
                end else if (i_in.dst_kind == xibe_pkg::KIND_MEM) begin
                    n_dec.op0 = 8'hFF;
                    n_dec.has_rm = 1'b1;
                    n_dec.rm_mem = 1'b1;
                    n_dec.rm_reg = (i_in.opcode == xibe_pkg::OP_INC) ? 3'd0 : 3'd1;
                end else begin
                    n_dec.bad = 1'b1;
                end
            end
            xibe_pkg::OP_MUL, xibe_pkg::OP_DIV: begin
                n_dec.op0 = 8'hF7;
                n_dec.has_rm = 1'b1;
                n_dec.rm_mem = (i_in.dst_kind == xibe_pkg::KIND_MEM);
                n_dec.rm_direct = i_in.dst_reg;
                n_dec.rm_reg = (i_in.opcode == xibe_pkg::OP_MUL) ? 3'd4 : 3'd6;
                n_dec.bad = (i_in.dst_kind != xibe_pkg::KIND_REG
                             && i_in.dst_kind != xibe_pkg::KIND_MEM);
            end
            xibe_pkg::OP_JE: begin
                n_dec.n_op = 2'd2;
                n_dec.op0 = 8'h0F;
                n_dec.op1 = 8'h84;
                n_dec.n_imm = 2'd2;
            end
            xibe_pkg::OP_RET: n_dec.op0 = 8'hC3;
            default: n_dec.bad = 1'b1;
        endcase
        if (!n_dec.has_rm) n_dec.rm_mem = 1'b0;

        // memory operand
        n_mem = '0;
        hb = (i_in.mem_base < 4'd8);
        hi = (i_in.mem_index < 4'd8);
        n_mem.disp = i_in.mem_disp;
        n_mem.bad = hi && (i_in.mem_index[2:0] == 3'd4);
        if (i_in.mem_disp == 32'd0 && i_in.mem_base != 4'd5) md = 2'd0;
        else if (xibe_pkg::fits8(i_in.mem_disp)) md = 2'd1;
        else md = 2'd2;
        if (!hb && !hi) begin
            n_mem.modrm = {2'b00, n_dec.rm_reg, 3'b101};
            n_mem.n_disp = 2'd2;
        end else if (!hb) begin
            n_mem.modrm = {2'b00, n_dec.rm_reg, 3'b100};
            n_mem.has_sib = 1'b1;
            n_mem.sib = {i_in.mem_scale, i_in.mem_index[2:0], 3'b101};
            n_mem.n_disp = 2'd2;
        end else begin
            n_mem.has_sib = (i_in.mem_base == 4'd4) || hi;
            n_mem.modrm = {md, n_dec.rm_reg,
                           n_mem.has_sib ? 3'b100 : i_in.mem_base[2:0]};
            n_mem.sib = {hi ? i_in.mem_scale : 2'b00, hi ? i_in.mem_index[2:0] : 3'd4,
                         i_in.mem_base[2:0]};
            n_mem.n_disp = md;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dec <= n_dec;
            r_mem <= n_mem;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
    assign o_mem   = r_mem;
endmodule
`default_nettype wire

@@ rtl/xibe_assemble.sv @@
// Stage 2: lays the decoded pieces into a byte frame with a length.
`default_nettype none
module xibe_assemble (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire xibe_pkg::t_dec  i_dec,
    input  wire xibe_pkg::t_mem  i_mem,
    output logic                 o_valid,
    output xibe_pkg::t_frame     o_frame
);
    xibe_pkg::t_frame n_frame, r_frame;
    logic r_valid;
    logic [xibe_pkg::CntW-1:0] p;

    always_comb begin
        n_frame = '0;
        p = '0;
        n_frame.bytes[p] = i_dec.op0;
        p = p + 1'b1;
        if (i_dec.n_op == 2'd2) begin
            n_frame.bytes[p] = i_dec.op1;
            p = p + 1'b1;
        end
        if (i_dec.has_rm) begin
            if (!i_dec.rm_mem) begin
                n_frame.bytes[p] = {2'b11, i_dec.rm_reg, i_dec.rm_direct};
                p = p + 1'b1;
            end else begin
                n_frame.bytes[p] = i_mem.modrm;
                p = p + 1'b1;
                if (i_mem.has_sib) begin
                    n_frame.bytes[p] = i_mem.sib;
                    p = p + 1'b1;
                end
                if (i_mem.n_disp == 2'd1) begin
                    n_frame.bytes[p] = i_mem.disp[7:0];
                    p = p + 1'b1;
                end else if (i_mem.n_disp == 2'd2) begin
                    for (int k = 0; k < 4; k++) begin
                        n_frame.bytes[p] = i_mem.disp[8*k +: 8];
                        p = p + 1'b1;
                    end
                end
            end
        end
        if (i_dec.n_imm == 2'd1) begin
            n_frame.bytes[p] = i_dec.imm[7:0];
            p = p + 1'b1;
        end else if (i_dec.n_imm == 2'd2) begin
            for (int k = 0; k < 4; k++) begin
                n_frame.bytes[p] = i_dec.imm[8*k +: 8];
                p = p + 1'b1;
            end
        end
        n_frame.bad = i_dec.bad || (i_dec.rm_mem && i_mem.bad);
        n_frame.len = n_frame.bad ? xibe_pkg::CntW'(1) : p;
        if (n_frame.bad) n_frame.bytes = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) r_frame <= n_frame;
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;
endmodule
`default_nettype wire

@@ rtl/xibe_serialise.sv @@
// Stage 3: frame buffer that shifts bytes out one word at a time.
`default_nettype none
module xibe_serialise (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire xibe_pkg::t_frame i_frame,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output xibe_pkg::t_result     o_res
);
    logic [xibe_pkg::CntW-1:0] r_left;
    logic [xibe_pkg::MaxBytes-1:0][7:0] r_bytes;
    logic r_bad;
    logic take, done;

    assign o_valid = (r_left != '0);
    assign done    = o_valid && i_ready && (r_left == xibe_pkg::CntW'(1));
    assign o_ready = !o_valid || done;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (take) begin
            r_left <= i_frame.len;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 1'b1;
        end
        if (take) begin
            r_bytes <= i_frame.bytes;
            r_bad   <= i_frame.bad;
        end else if (o_valid && i_ready) begin
            r_bytes <= {8'd0, r_bytes[xibe_pkg::MaxBytes-1:1]};
        end
    end

    assign o_res.code_byte = r_bytes[0];
    assign o_res.last_byte = (r_left == xibe_pkg::CntW'(1));
    assign o_res.bad_form  = r_bad;
endmodule
`default_nettype wire

@@ rtl/x86_instruction_byte_encoder_core.sv @@
// Top level: x86 instruction byte encoder, decode / assemble / serialise pipeline.
// One instruction word in gives 1 to 11 byte words out, the last flagged; an unsupported
// form gives one zero word with bad_form. Three register stages (decode, byte assembly,
// output shifter): a word is registered in decode, then in assembly, then loaded into the
// single byte-wide output shifter, which sends one byte per output handshake (at most 11
// per instruction) and loads the next frame as the last byte of the current one is taken.
`default_nettype none
module x86_instruction_byte_encoder_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xibe_if.sink      i_in,
    xibe_if.source    o_out
);
    logic s1_valid, s2_valid, en, ser_ready;
    xibe_pkg::t_dec s1_dec;
    xibe_pkg::t_mem s1_mem;
    xibe_pkg::t_frame s2_frame;

    assign en = !s2_valid || ser_ready;
    assign i_in.ready = en;

    xibe_decode u_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in.valid),
        .i_in(i_in.data), .o_valid(s1_valid), .o_dec(s1_dec), .o_mem(s1_mem)
    );

    xibe_assemble u_asm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s1_valid),
        .i_dec(s1_dec), .i_mem(s1_mem), .o_valid(s2_valid), .o_frame(s2_frame)
    );

    xibe_serialise u_ser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s2_valid), .o_ready(ser_ready),
        .i_frame(s2_frame), .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_res(o_out.data)
    );

    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.bad_form |-> o_out.data.last_byte
            && o_out.data.code_byte == 8'd0)
        else $error("bad form word not single zero byte");
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid |-> s2_frame.len != '0 && s2_frame.len <= xibe_pkg::CntW'(xibe_pkg::MaxBytes))
        else $error("frame length out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && !ser_ready |=> s2_valid && $stable(s2_frame))
        else $error("frame lost while stalled");
endmodule
`default_nettype wire
